@@ rtl/b64c_pkg.sv @@
package b64c_pkg;

   localparam int unsigned CMD_DEPTH = 4;
   localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_BAD_CHAR   = 2'd1;
   localparam logic [1:0] ST_INCOMPLETE = 2'd2;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       out_last;
      logic [1:0] status;
   } rsp_type;

   // one finished group handed from front to back
   typedef struct packed {
      logic [23:0] bits;
      logic        mode;
      logic [2:0]  chars;
      logic [1:0]  last_idx;
      logic        last;
      logic [1:0]  status;
      logic        data;
   } cmd_type;

   function automatic logic [7:0] enc_char(input logic [5:0] v);
      logic [7:0] r;
      r = 8'h2F;
      if (v < 6'd26) begin
         r = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         r = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         r = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         r = 8'h2B;
      end
      return r;
   endfunction

   // bit 6 set: not in the alphabet
   function automatic logic [6:0] dec_sextet(input logic [7:0] c);
      logic [6:0] r;
      r = 7'h40;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = {1'b0, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r = {1'b0, 6'(c - 8'h61 + 8'd26)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b0, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2B) begin
         r = 7'd62;
      end else if (c == 8'h2F) begin
         r = 7'd63;
      end
      return r;
   endfunction

endpackage

@@ rtl/b64c_front.sv @@
module b64c_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  b64c_pkg::req_type  req_data,
   input  logic               csr_we,
   input  logic               csr_wdata,
   input  logic               q_full,
   output logic               q_push,
   output b64c_pkg::cmd_type  q_cmd
);

   logic        dir_ff, dir_in;
   logic [23:0] bits_ff, bits_in;
   logic [1:0]  fill_ff, fill_in;
   logic [1:0]  marks_ff, marks_in;
   logic        bad_ff, bad_in;

   logic        accept;
   logic [2:0]  fill_n;
   logic [23:0] enc_bits, dec_bits;
   logic [6:0]  sx;
   logic [5:0]  s6;
   logic        is_pad;
   logic [1:0]  marks_n;
   logic        bad_n;
   logic [1:0]  m_cut1, m_cut0;

   assign accept = req_push && !q_full;
   assign fill_n = {1'b0, fill_ff} + 3'd1;
   assign is_pad = (req_data.in_byte == b64c_pkg::PAD_CHAR);
   assign sx     = b64c_pkg::dec_sextet(req_data.in_byte);
   assign s6     = (is_pad || sx[6]) ? 6'd0 : sx[5:0];
   assign bad_n  = bad_ff || (!is_pad && sx[6]);

   always_comb begin
      marks_n = marks_ff;
      if (is_pad && fill_ff == 2'd2) begin
         marks_n[1] = 1'b1;
      end
      if (is_pad && fill_ff == 2'd3) begin
         marks_n[0] = 1'b1;
      end
   end

   always_comb begin
      case (fill_ff)
         2'd0:    enc_bits = bits_ff | {req_data.in_byte, 16'h0};
         2'd1:    enc_bits = bits_ff | {8'h0, req_data.in_byte, 8'h0};
         default: enc_bits = bits_ff | {16'h0, req_data.in_byte};
      endcase
      case (fill_ff)
         2'd0:    dec_bits = bits_ff | {s6, 18'h0};
         2'd1:    dec_bits = bits_ff | {6'h0, s6, 12'h0};
         2'd2:    dec_bits = bits_ff | {12'h0, s6, 6'h0};
         default: dec_bits = bits_ff | {18'h0, s6};
      endcase
   end

   assign m_cut1 = {1'b0, req_data.in_last & marks_n[1]};
   assign m_cut0 = {1'b0, req_data.in_last & marks_n[0]};

   always_comb begin
      dir_in   = dir_ff;
      bits_in  = bits_ff;
      fill_in  = fill_ff;
      marks_in = marks_ff;
      bad_in   = bad_ff;
      q_push   = 1'b0;
      q_cmd    = '0;
      q_cmd.mode = dir_ff;
      if (csr_we) begin
         dir_in   = csr_wdata;
         bits_in  = '0;
         fill_in  = '0;
         marks_in = '0;
         bad_in   = 1'b0;
      end else if (accept) begin
         if (dir_ff == b64c_pkg::DIR_ENCODE) begin
            if (fill_n == 3'd3 || req_data.in_last) begin
               q_push         = 1'b1;
               q_cmd.bits     = enc_bits;
               q_cmd.chars    = fill_n + 3'd1;
               q_cmd.last_idx = 2'd3;
               q_cmd.last     = req_data.in_last;
               q_cmd.status   = b64c_pkg::ST_OK;
               q_cmd.data     = 1'b1;
               bits_in        = '0;
               fill_in        = '0;
            end else begin
               bits_in = enc_bits;
               fill_in = fill_n[1:0];
            end
         end else begin
            if (fill_n == 3'd4) begin
               q_push         = 1'b1;
               q_cmd.bits     = dec_bits;
               q_cmd.chars    = 3'd4;
               q_cmd.last_idx = 2'd2 - m_cut1 - m_cut0;
               q_cmd.last     = req_data.in_last;
               q_cmd.status   = bad_n ? b64c_pkg::ST_BAD_CHAR : b64c_pkg::ST_OK;
               q_cmd.data     = 1'b1;
               bits_in        = '0;
               fill_in        = '0;
               marks_in       = '0;
               bad_in         = 1'b0;
            end else if (req_data.in_last) begin
               q_push         = 1'b1;
               q_cmd.bits     = '0;
               q_cmd.chars    = 3'd4;
               q_cmd.last_idx = 2'd0;
               q_cmd.last     = 1'b1;
               q_cmd.status   = b64c_pkg::ST_INCOMPLETE;
               q_cmd.data     = 1'b0;
               bits_in        = '0;
               fill_in        = '0;
               marks_in       = '0;
               bad_in         = 1'b0;
            end else begin
               bits_in  = dec_bits;
               fill_in  = fill_n[1:0];
               marks_in = marks_n;
               bad_in   = bad_n;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff   <= b64c_pkg::DIR_ENCODE;
         bits_ff  <= '0;
         fill_ff  <= '0;
         marks_ff <= '0;
         bad_ff   <= 1'b0;
      end else begin
         dir_ff   <= dir_in;
         bits_ff  <= bits_in;
         fill_ff  <= fill_in;
         marks_ff <= marks_in;
         bad_ff   <= bad_in;
      end
   end

endmodule

@@ rtl/b64c_cmd_queue.sv @@
module b64c_cmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  b64c_pkg::cmd_type  push_cmd,
   input  logic               pop,
   output b64c_pkg::cmd_type  head_cmd,
   output logic               full,
   output logic               empty
);

   b64c_pkg::cmd_type entry_ff [b64c_pkg::CMD_DEPTH];

   logic [b64c_pkg::CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [b64c_pkg::CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [b64c_pkg::CMD_CNT_W-1:0] count_ff, count_in;
   logic                           do_push, do_pop;

   assign full     = (count_ff == b64c_pkg::CMD_CNT_W'(b64c_pkg::CMD_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == b64c_pkg::CMD_PTR_W'(b64c_pkg::CMD_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == b64c_pkg::CMD_PTR_W'(b64c_pkg::CMD_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/b64c_back.sv @@
module b64c_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  b64c_pkg::cmd_type  q_cmd,
   output logic               q_pop,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output b64c_pkg::rsp_type  rsp_data
);

   logic [1:0]        idx_ff, idx_in;
   logic              vld_ff, vld_in;
   b64c_pkg::rsp_type out_ff, out_in;

   logic              advance;
   logic              at_end;
   logic [5:0]        sextet;
   logic [7:0]        dbyte;
   logic [7:0]        ebyte;

   assign advance = !q_empty && (!vld_ff || rsp_pop);
   assign at_end  = (idx_ff == q_cmd.last_idx);
   assign q_pop   = advance && at_end;

   always_comb begin
      case (idx_ff)
         2'd0:    sextet = q_cmd.bits[23:18];
         2'd1:    sextet = q_cmd.bits[17:12];
         2'd2:    sextet = q_cmd.bits[11:6];
         default: sextet = q_cmd.bits[5:0];
      endcase
      case (idx_ff)
         2'd0:    dbyte = q_cmd.bits[23:16];
         2'd1:    dbyte = q_cmd.bits[15:8];
         default: dbyte = q_cmd.bits[7:0];
      endcase
   end

   // pad characters past the real ones
   assign ebyte = ({1'b0, idx_ff} >= q_cmd.chars) ? b64c_pkg::PAD_CHAR :
                  b64c_pkg::enc_char(sextet);

   always_comb begin
      idx_in = idx_ff;
      vld_in = vld_ff;
      out_in = out_ff;
      if (advance) begin
         vld_in           = 1'b1;
         out_in.out_byte  = (q_cmd.mode == b64c_pkg::DIR_ENCODE) ? ebyte : dbyte;
         out_in.out_valid = q_cmd.data;
         out_in.out_last  = q_cmd.last && at_end;
         out_in.status    = q_cmd.status;
         idx_in           = at_end ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_pop) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty = !vld_ff;
   assign rsp_data  = out_ff;

endmodule

@@ rtl/base64_stream_codec.sv @@
// Streaming base64 codec, standard alphabet with '=' padding. csr_wdata 0 encodes bytes
// into characters (each three-byte group, or the shorter final one, gives four beats),
// 1 decodes characters into bytes (each four-character group gives three beats, fewer
// when the final group ends in '='; a short final group gives one status-only beat).
// Writing the csr drops any partial group; write it only while the block is idle.
// A beat enters every cycle unless req_full is set; results leave one beat per cycle
// while rsp_pop is held; decoding sustains one input beat per cycle, encoding fewer.
// A four-deep group queue between input and output lets each side stall on its own;
// with the output side idle, the first result of a group is registered onto the result
// ports from the queue entry written at the edge that accepts the beat completing the group.
module base64_stream_codec (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  b64c_pkg::req_type  req_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output b64c_pkg::rsp_type  rsp_data,
   input  logic               csr_we,
   input  logic               csr_wdata
);

   logic              q_push, q_pop, q_full, q_empty;
   b64c_pkg::cmd_type q_in, q_head;

   assign req_full = q_full;

   b64c_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_in)
   );

   b64c_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_in),
      .pop      (q_pop),
      .head_cmd (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   b64c_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_cmd     (q_head),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/b64c_checker.sv @@
module b64c_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_full,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  b64c_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_wdata
);

   logic dir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= b64c_pkg::DIR_ENCODE;
      end else if (csr_we) begin
         dir_ff <= csr_wdata;
      end
   end

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("waiting beat changed");

   a_enc_clean: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && dir_ff == b64c_pkg::DIR_ENCODE |->
         rsp_data.status == b64c_pkg::ST_OK && rsp_data.out_valid)
      else $error("encode beat with status or no data");

   a_incomplete: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.status == b64c_pkg::ST_INCOMPLETE |->
         rsp_data.out_last && !rsp_data.out_valid && rsp_data.out_byte == 8'h00)
      else $error("bad incomplete-group beat");

   a_nodata_status: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_data.out_valid |->
         rsp_data.status == b64c_pkg::ST_INCOMPLETE)
      else $error("status-only beat without incomplete status");

endmodule

bind base64_stream_codec b64c_checker u_b64c_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data),
   .csr_we    (csr_we),
   .csr_wdata (csr_wdata)
);

@@ dv/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 60000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 6;
   localparam logic [8*64-1:0] ALPHA =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_push = 1'b0;
   logic              req_full;
   b64c_pkg::req_type req_data = '0;
   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   b64c_pkg::rsp_type rsp_data;
   logic              csr_we = 1'b0;
   logic              csr_wdata = 1'b0;

   // codec state mirrored on the testbench side
   logic        codec_dir = b64c_pkg::DIR_ENCODE;
   logic [23:0] grp_bits = '0;
   int          grp_fill = 0;
   logic [1:0]  pad_marks = '0;
   logic        bad_seen = 1'b0;

   b64c_pkg::rsp_type coded_q[$];
   int      fails = 0;
   int      sent_beats = 0;
   int      cycle_count;
   logic    idle_en = 1'b1;
   int      hold_asked = 0;
   int      hold_served = 0;
   int      hold_left = 0;

   base64_stream_codec dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic void drop_group();
      grp_bits = '0;
      grp_fill = 0;
      pad_marks = '0;
      bad_seen = 1'b0;
   endfunction

   function automatic logic [7:0] b64_rand_char();
      int v;
      v = $urandom_range(63);
      return ALPHA[8*(63-v) +: 8];
   endfunction

   // expected output beats for one accepted input beat
   function automatic void code_beat(input b64c_pkg::req_type beat);
      int f;
      int v;
      int s;
      int n_bytes;
      logic [7:0] c;
      b64c_pkg::rsp_type r;
      f = grp_fill;
      c = beat.in_byte;
      if (codec_dir == b64c_pkg::DIR_ENCODE) begin
         if (f > 2) begin
            drop_group();
            f = 0;
         end
         grp_bits = grp_bits | (24'(c) << (16 - 8*f));
         f++;
         if (f == 3 || beat.in_last) begin
            for (int i = 0; i < 4; i++) begin
               r.out_byte = b64c_pkg::PAD_CHAR;
               if (i <= f) begin
                  v = int'((grp_bits >> (18 - 6*i)) & 24'h3F);
                  r.out_byte = ALPHA[8*(63-v) +: 8];
               end
               r.out_valid = 1'b1;
               r.out_last = beat.in_last && i == 3;
               r.status = b64c_pkg::ST_OK;
               coded_q.push_back(r);
            end
            drop_group();
         end else begin
            grp_fill = f;
         end
      end else begin
         s = 64;
         if (c == b64c_pkg::PAD_CHAR) begin
            s = 0;
            if (f == 2) pad_marks[1] = 1'b1;
            if (f == 3) pad_marks[0] = 1'b1;
         end else begin
            for (int k = 0; k < 64; k++) begin
               if (ALPHA[8*(63-k) +: 8] == c) s = k;
            end
            if (s == 64) begin
               bad_seen = 1'b1;
               s = 0;
            end
         end
         grp_bits = grp_bits | (24'(s) << (18 - 6*f));
         f++;
         if (f == 4) begin
            n_bytes = 3;
            if (beat.in_last) begin
               if (pad_marks[0]) n_bytes--;
               if (pad_marks[1]) n_bytes--;
            end
            for (int i = 0; i < n_bytes; i++) begin
               r.out_byte = grp_bits[16 - 8*i +: 8];
               r.out_valid = 1'b1;
               r.out_last = beat.in_last && i + 1 == n_bytes;
               r.status = bad_seen ? b64c_pkg::ST_BAD_CHAR : b64c_pkg::ST_OK;
               coded_q.push_back(r);
            end
            drop_group();
         end else if (beat.in_last) begin
            r.out_byte = 8'h00;
            r.out_valid = 1'b0;
            r.out_last = 1'b1;
            r.status = b64c_pkg::ST_INCOMPLETE;
            coded_q.push_back(r);
            drop_group();
         end else begin
            grp_fill = f;
         end
      end
   endfunction

   task automatic send_beat(input logic [7:0] b, input logic last);
      b64c_pkg::req_type beat;
      beat.in_byte = b;
      beat.in_last = last;
      while (idle_en && $urandom_range(99) < 14) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_full) @(posedge clock);
      code_beat(beat);
      sent_beats++;
   endtask

   task automatic send_text(input string s, input logic last);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], last && i == s.len() - 1);
   endtask

   task automatic wait_quiet();
      req_push <= 1'b0;
      while (coded_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_direction(input logic dir);
      wait_quiet();
      csr_we <= 1'b1;
      csr_wdata <= dir;
      @(posedge clock);
      csr_we <= 1'b0;
      codec_dir = dir;
      drop_group();
   endtask

   task automatic send_encode_message();
      int len;
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) send_beat(8'($urandom_range(255)), i == len - 1);
   endtask

   task automatic send_decode_message();
      int groups;
      int pads;
      int len;
      logic [7:0] c;
      if ($urandom_range(99) < 80) begin
         groups = $urandom_range(1, 3);
         for (int g = 0; g < groups; g++) begin
            pads = (g == groups - 1) ? $urandom_range(0, 2) : 0;
            for (int p = 0; p < 4; p++) begin
               c = (p >= 4 - pads) ? b64c_pkg::PAD_CHAR : b64_rand_char();
               send_beat(c, g == groups - 1 && p == 3);
            end
         end
      end else begin
         // noise: stray characters, pads anywhere, short groups
         len = $urandom_range(1, 9);
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(2))
               0: c = 8'($urandom_range(255));
               1: c = b64c_pkg::PAD_CHAR;
               default: c = b64_rand_char();
            endcase
            send_beat(c, i == len - 1);
         end
      end
   endtask

   task automatic test_encode_directed();
      set_direction(b64c_pkg::DIR_ENCODE);
      send_beat(8'h00, 1'b1);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h7E, 1'b1);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h80, 1'b0);
      send_beat(8'h01, 1'b0);
      send_beat(8'h55, 1'b0);
      send_beat(8'hAA, 1'b0);
      send_beat(8'h00, 1'b1);
   endtask

   // a csr write drops the partial group
   task automatic test_group_drop();
      send_beat(8'h12, 1'b0);
      send_beat(8'h34, 1'b0);
      set_direction(b64c_pkg::DIR_ENCODE);
      send_beat(8'hFF, 1'b1);
   endtask

   task automatic test_decode_directed();
      set_direction(b64c_pkg::DIR_DECODE);
      send_text("+/9=", 1'b1);
      send_text("Az==", 1'b1);
      send_text("=Z=", 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat("Q", 1'b0);
      send_beat(8'hFF, 1'b1);
   endtask

   task automatic test_random_encode();
      int start;
      set_direction(b64c_pkg::DIR_ENCODE);
      start = sent_beats;
      idle_en <= 1'b0;
      while (sent_beats - start < 70) send_encode_message();
      idle_en <= 1'b1;
      while (sent_beats - start < 180) send_encode_message();
   endtask

   task automatic test_random_decode();
      int start;
      set_direction(b64c_pkg::DIR_DECODE);
      start = sent_beats;
      while (sent_beats - start < 190) send_decode_message();
   endtask

   task automatic test_backpressure();
      int start;
      set_direction(b64c_pkg::DIR_ENCODE);
      start = sent_beats;
      hold_asked <= hold_asked + 1;
      while (sent_beats - start < 40) send_encode_message();
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         fails++;
      end
   endtask

   // result side: check each popped beat and decide the next pop
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (coded_q.size() == 0) begin
               $display("%0t: unexpected beat %h", $time, rsp_data);
               fails++;
            end else begin
               check_field("out_byte", int'(coded_q[0].out_byte),
                           int'(rsp_data.out_byte));
               check_field("out_valid", int'(coded_q[0].out_valid),
                           int'(rsp_data.out_valid));
               check_field("out_last", int'(coded_q[0].out_last),
                           int'(rsp_data.out_last));
               check_field("status", int'(coded_q[0].status), int'(rsp_data.status));
               void'(coded_q.pop_front());
            end
         end
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= !(idle_en && $urandom_range(99) < 14);
         end
      end
   end

   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_encode_directed();
      test_group_drop();
      test_decode_directed();
      test_random_encode();
      test_random_decode();
      test_backpressure();
      wait_quiet();
      repeat (20) @(posedge clock);
      if (fails == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/b64c_pkg.sv
rtl/b64c_front.sv
rtl/b64c_cmd_queue.sv
rtl/b64c_back.sv
rtl/base64_stream_codec.sv
rtl/b64c_checker.sv
dv/testbench.sv
